// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every rising clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// implication checked at every rising clock edge out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/uges_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uges_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam int VERTEX_W  = 6;
    localparam int CFG_W     = 7;
    localparam int EDGE_W    = 11;
    localparam int DEG_OUT_W = 6;
    localparam int STATUS_W  = 2;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPLIED = 2'd0,
        ST_IGNORED = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_WRITE_B,
        S_SCAN
    } t_state;

endpackage

`default_nettype wire

// ===== src/undirected_graph_edge_store_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Edge store for a simple undirected graph. An item is taken when start is high and busy is
// low; one result follows on o_valid for a single cycle, and the receiver cannot stall it.
// The item passes a lookup state and, when both vertices are in range, a check state; an
// applied edge then also writes the second row, while an ignored or out-of-range item goes
// straight to the sweep. With n the active vertex count limited to MAX_VERTICES, the sweep
// reads n degree entries, one entry per cycle through the single read port, to find
// the largest and smallest degree. The next item may be started in the cycle of the strobe.
// Both memories start out empty through per-entry valid bits, so no clearing pass follows
// reset. The active vertex count register is written through the cfg channel, which is
// ready only while busy is low.

`include "assert_macros.svh"

module undirected_graph_edge_store_core
    import uges_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_func,
    input  logic [VERTEX_W-1:0]  i_first_vertex,
    input  logic [VERTEX_W-1:0]  i_second_vertex,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_active_vertices,
    output logic                 o_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic [EDGE_W-1:0]    o_edge_count,
    output logic [DEG_OUT_W-1:0] o_max_degree,
    output logic [DEG_OUT_W-1:0] o_min_degree
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int DW = AW;
    localparam int CW = (NW > CFG_W) ? NW : CFG_W;

    t_state                   r_state;
    t_state                   n_state;
    logic [CFG_W-1:0]         r_active;
    t_func                    r_func;
    logic [VERTEX_W-1:0]      r_a;
    logic [VERTEX_W-1:0]      r_b;
    logic [NW-1:0]            r_n;
    logic [NW-1:0]            r_idx;
    logic                     r_pend;
    logic                     r_first;
    logic [DW-1:0]            r_max;
    logic [DW-1:0]            r_min;
    t_status                  r_status;
    logic [EDGE_W-1:0]        r_edge_total;

    logic [MAX_VERTICES-1:0]  r_row_mem [MAX_VERTICES];
    logic [DW-1:0]            r_deg_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]  r_ent_vld;
    logic [MAX_VERTICES-1:0]  r_row_q;
    logic [DW-1:0]            r_deg_q;
    logic                     r_q_vld;

    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [EDGE_W-1:0]        r_out_edges;
    logic [DW-1:0]            r_out_max;
    logic [DW-1:0]            r_out_min;

    logic                     take;
    logic [CW-1:0]            act_ext;
    logic [NW-1:0]            n_lim;
    logic [AW-1:0]            a_idx;
    logic [AW-1:0]            b_idx;
    logic                     in_range;
    logic [MAX_VERTICES-1:0]  row_eff;
    logic [DW-1:0]            deg_eff;
    logic                     hit;
    logic                     apply;
    logic                     ins;
    logic                     scan_done;

    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            bit_pos;
    logic                     mem_we;
    logic [MAX_VERTICES-1:0]  wr_row;
    logic [DW-1:0]            wr_deg;

    assign take      = start && !busy;
    assign act_ext   = CW'(r_active);
    assign n_lim     = (act_ext > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(act_ext);
    assign a_idx     = AW'(r_a);
    assign b_idx     = AW'(r_b);
    assign in_range  = (CW'(r_a) < CW'(r_n)) && (CW'(r_b) < CW'(r_n));
    assign row_eff   = r_q_vld ? r_row_q : '0;
    assign deg_eff   = r_q_vld ? r_deg_q : '0;
    assign hit       = row_eff[b_idx];
    assign ins       = (r_func == FUNC_INSERT);
    assign apply     = (r_a != r_b) && (ins ? !hit : hit);
    assign scan_done = (r_idx == r_n) && !r_pend;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = in_range ? S_CHECK : S_SCAN;
            end
            S_CHECK: begin
                n_state = apply ? S_WRITE_B : S_SCAN;
            end
            S_WRITE_B: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory control, busy and cfg ready
    always_comb begin
        rd_addr     = r_idx[AW-1:0];
        wr_addr     = a_idx;
        bit_pos     = b_idx;
        mem_we      = 1'b0;
        busy        = 1'b1;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy        = 1'b0;
                o_cfg_ready = 1'b1;
            end
            S_LOOKUP: begin
                rd_addr = a_idx;
            end
            S_CHECK: begin
                rd_addr = b_idx;
                mem_we  = apply;
            end
            S_WRITE_B: begin
                mem_we  = 1'b1;
                wr_addr = b_idx;
                bit_pos = a_idx;
            end
            S_SCAN: begin
                rd_addr = r_idx[AW-1:0];
            end
            default: begin
                busy = 1'b1;
            end
        endcase
        wr_row          = row_eff;
        wr_row[bit_pos] = ins;
        wr_deg          = ins ? (deg_eff + DW'(1)) : (deg_eff - DW'(1));
    end

    // adjacency rows and degrees
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_row_mem[wr_addr] <= wr_row;
            r_deg_mem[wr_addr] <= wr_deg;
        end
        r_row_q <= r_row_mem[rd_addr];
        r_deg_q <= r_deg_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_q_vld   <= 1'b0;
        end else begin
            if (mem_we) begin
                r_ent_vld[wr_addr] <= 1'b1;
            end
            r_q_vld <= r_ent_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= ACTIVE_RESET;
            r_edge_total <= '0;
            r_n          <= '0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_first      <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_active_vertices;
            end
            if (take) begin
                r_n     <= n_lim;
                r_idx   <= '0;
                r_first <= 1'b1;
            end
            if (r_state == S_WRITE_B) begin
                r_edge_total <= ins ? (r_edge_total + EDGE_W'(1))
                                    : (r_edge_total - EDGE_W'(1));
            end
            if ((r_state == S_SCAN) && (r_idx != r_n)) begin
                r_idx <= r_idx + NW'(1);
            end
            r_pend <= (r_state == S_SCAN) && (r_idx != r_n);
            if (r_pend) begin
                r_first <= 1'b0;
            end
            r_out_valid <= (r_state == S_SCAN) && scan_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_func <= t_func'(i_func);
            r_a    <= i_first_vertex;
            r_b    <= i_second_vertex;
            r_max  <= '0;
            r_min  <= '0;
        end
        if ((r_state == S_LOOKUP) && !in_range) begin
            r_status <= ST_RANGE;
        end
        if ((r_state == S_CHECK) && !apply) begin
            r_status <= ST_IGNORED;
        end
        if (r_state == S_WRITE_B) begin
            r_status <= ST_APPLIED;
        end
        if (r_pend) begin
            if (r_first) begin
                r_max <= deg_eff;
                r_min <= deg_eff;
            end else begin
                if (deg_eff > r_max) begin
                    r_max <= deg_eff;
                end
                if (deg_eff < r_min) begin
                    r_min <= deg_eff;
                end
            end
        end
        if ((r_state == S_SCAN) && scan_done) begin
            r_out_status <= r_status;
            r_out_edges  <= r_edge_total;
            r_out_max    <= r_max;
            r_out_min    <= r_min;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_edge_count = r_out_edges;
    assign o_max_degree = DEG_OUT_W'(r_out_max);
    assign o_min_degree = DEG_OUT_W'(r_out_min);

    `ASSERT_ALWAYS(a_scan_bound, r_idx <= r_n, "scan index ran past the active count")
    `ASSERT_IMPL(a_check_rw_apart, (r_state == S_CHECK) && mem_we, rd_addr != wr_addr,
        "row write and row read hit the same entry")
    `ASSERT_IMPL(a_remove_nonzero, mem_we && (r_func == FUNC_REMOVE), deg_eff != '0,
        "degree underflow on edge removal")
    `ASSERT_IMPL(a_result_after_scan, o_valid, $past(r_state) == S_SCAN,
        "result strobe without a finished scan")

endmodule

`default_nettype wire
